// ===== rtl/fhdc_pkg.sv =====
// Shared types, constants and float helpers of the hash dedup cache.
package fhdc_pkg;

    localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
    localparam logic [31:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [31:0] ABS_MASK  = 32'h7FFF_FFFF;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

    // pending queue: depth and widths of its count and index
    localparam int PEND_DEPTH = 4;
    localparam int PEND_W     = 3;
    localparam int PIDX_W     = 2;

    typedef enum logic [0:0] {
        FOP_ADD = 1'b0,
        FOP_MUL = 1'b1
    } t_fop;

    // item travelling down the cell chain
    typedef struct packed {
        logic        valid;
        logic        match;
        logic [31:0] hash;
    } t_probe;

    function automatic logic [31:0] flush_bits(input logic [31:0] b);
        flush_bits = ((b & EXP_MASK) == 32'd0) ? (b & SIGN_MASK) : b;
    endfunction

    function automatic logic is_nan(input logic [31:0] b);
        is_nan = (b & ABS_MASK) > EXP_MASK;
    endfunction

    // stored value (raw) against an already flushed probe
    function automatic logic hash_eq(input logic [31:0] st, input logic [31:0] pr);
        logic [31:0] f;
        f = flush_bits(st);
        if (is_nan(f) || is_nan(pr)) begin
            hash_eq = 1'b0;
        end else if (((f & ABS_MASK) == 32'd0) && ((pr & ABS_MASK) == 32'd0)) begin
            hash_eq = 1'b1;
        end else begin
            hash_eq = (f == pr);
        end
    endfunction

endpackage

// ===== rtl/float_hash_dedup_ring_cache_core.sv =====
// Top level of the triangle hash dedup cache with its ring of hash packs.
//
//  channel   direction  handshake                   payload
//  command   in         i_start && !o_busy          i_func, i_v1y..i_v2z, i_surface_tag,
//                                                   i_valid_word, i_batch_last
//  result    out        o_done (one-cycle strobe)   o_skipped, o_duplicate, o_inserted,
//                                                   o_slot_pack, o_slot_lane, o_hash_bits
//  config    in         i_cfg_valid && o_cfg_ready  i_cfg_data (invisible surface id)
//
// One item at a time. The hash is five float ops through one shared
// unit; each op is issued once the result of the op before it is back.
// A searched triangle then runs down the chain of PACKS cells and, unless
// it is a duplicate, takes a slot in the insert state (a full pending queue
// is committed first); the queue is committed at a batch end, then the
// result state follows. Skipped items bypass the chain; a crash item commits.
// Reset is synchronous, active low; stored hashes clear at once with it.
// The result strobe lasts one cycle and cannot be held off; the config port
// is always ready.
module float_hash_dedup_ring_cache_core #(
    parameter int PACKS = 48,
    parameter int LANES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_func,
    input  logic [31:0]                 i_v1y,
    input  logic [31:0]                 i_v1z,
    input  logic [31:0]                 i_v2x,
    input  logic [31:0]                 i_v2y,
    input  logic [31:0]                 i_v2z,
    input  logic [31:0]                 i_surface_tag,
    input  logic [31:0]                 i_valid_word,
    input  logic                        i_batch_last,
    output logic                        o_done,
    output logic                        o_skipped,
    output logic                        o_duplicate,
    output logic                        o_inserted,
    output logic [$clog2(PACKS)-1:0]    o_slot_pack,
    output logic [$clog2(LANES)-1:0]    o_slot_lane,
    output logic [31:0]                 o_hash_bits,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [5:0]                  i_cfg_data
);

    localparam int PACK_W = $clog2(PACKS);
    localparam int LANE_W = $clog2(LANES);
    localparam int CNT_W  = $clog2(PACKS + 1);
    localparam int LP_W   = CNT_W + 1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_HASH   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_COMMIT = 6'b001000,
        ST_INS    = 6'b010000,
        ST_FIN    = 6'b100000
    } t_state;

    typedef enum logic [2:0] {
        HS_SUM  = 3'd0,     // s = v2x + v2y
        HS_MUL  = 3'd1,     // m = v1y * v1z
        HS_T    = 3'd2,     // t = m + s
        HS_P    = 3'd3,     // p = s * t
        HS_H    = 3'd4      // h = p + v2z
    } t_hstep;

    t_state r_state;
    t_hstep r_step;
    logic   r_issued;

    // latched item
    logic [31:0] r_v1y, r_v1z, r_v2x, r_v2y, r_v2z;
    logic        r_last, r_crash, r_ins_todo;
    logic [31:0] r_s, r_m, r_t;

    // surface id and a zero-exponent flag of the valid word are latched with the item
    logic [5:0]  r_surf;
    logic        r_vzero;

    // ring counters
    logic [CNT_W-1:0]  r_pack_count, r_bsc;
    logic [PACK_W-1:0] r_fill_pack;
    logic [LANE_W-1:0] r_fill_lane;

    // pending hashes, committed at batch end, on a crash or when full (no reset: read only below count)
    logic [31:0]             r_pend_hash [fhdc_pkg::PEND_DEPTH];
    logic [PACK_W-1:0]       r_pend_pack [fhdc_pkg::PEND_DEPTH];
    logic [LANE_W-1:0]       r_pend_lane [fhdc_pkg::PEND_DEPTH];
    logic [fhdc_pkg::PEND_W-1:0] r_pend_num, r_cidx;

    logic [5:0] r_invis;

    // result registers
    logic              r_skip, r_dup, r_ins;
    logic [PACK_W-1:0] r_opack;
    logic [LANE_W-1:0] r_olane;
    logic [31:0]       r_hb;

    // chain injection
    logic        r_inj_v;
    logic [31:0] r_inj_hash;

    // ---- float unit
    logic           w_fstart, w_fdone;
    fhdc_pkg::t_fop w_fop;
    logic [31:0]    w_fa, w_fb, w_fres;

    always_comb begin
        case (r_step)
            HS_SUM: begin w_fop = fhdc_pkg::FOP_ADD; w_fa = r_v2x; w_fb = r_v2y; end
            HS_MUL: begin w_fop = fhdc_pkg::FOP_MUL; w_fa = r_v1y; w_fb = r_v1z; end
            HS_T:   begin w_fop = fhdc_pkg::FOP_ADD; w_fa = r_m;   w_fb = r_s;   end
            HS_P:   begin w_fop = fhdc_pkg::FOP_MUL; w_fa = r_s;   w_fb = r_t;   end
            default: begin w_fop = fhdc_pkg::FOP_ADD; w_fa = r_t;  w_fb = r_v2z; end
        endcase
    end

    assign w_fstart = (r_state == ST_HASH) && !r_issued;

    fhdc_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_fstart),
        .i_op    (w_fop),
        .i_a     (w_fa),
        .i_b     (w_fb),
        .o_done  (w_fdone),
        .o_res   (w_fres)
    );

    // final hash, NaNs made canonical, and the skip test
    logic [31:0] w_hb;
    logic        w_skip;
    assign w_hb   = fhdc_pkg::is_nan(w_fres) ? fhdc_pkg::QNAN_BITS : w_fres;
    assign w_skip = (r_surf == r_invis);

    // ---- cell chain
    logic [LP_W-1:0]   w_lp_raw;
    logic [PACK_W-1:0] w_last_pack;
    logic              w_cwr;
    fhdc_pkg::t_probe  w_probe [PACKS+1];

    assign w_lp_raw    = {1'b0, r_bsc} + LP_W'(1);
    assign w_last_pack = (w_lp_raw > LP_W'(PACKS - 1)) ? PACK_W'(PACKS - 1)
                                                       : w_lp_raw[PACK_W-1:0];
    assign w_cwr       = (r_state == ST_COMMIT) && (r_cidx < r_pend_num);

    assign w_probe[0].valid = r_inj_v;
    assign w_probe[0].match = 1'b0;
    assign w_probe[0].hash  = r_inj_hash;

    for (genvar k = 0; k < PACKS; k++) begin : g_cell
        fhdc_cell #(
            .LANES  (LANES),
            .PACK_W (PACK_W),
            .LANE_W (LANE_W),
            .INDEX  (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_probe     (w_probe[k]),
            .i_last_pack (w_last_pack),
            .i_wr        (w_cwr),
            .i_wr_pack   (r_pend_pack[r_cidx[fhdc_pkg::PIDX_W-1:0]]),
            .i_wr_lane   (r_pend_lane[r_cidx[fhdc_pkg::PIDX_W-1:0]]),
            .i_wr_hash   (r_pend_hash[r_cidx[fhdc_pkg::PIDX_W-1:0]]),
            .o_probe     (w_probe[k+1])
        );
    end

    // counter row: a zero hash always matches once the ring is nearly full
    logic w_cnt_row, w_dup;
    assign w_cnt_row = (r_bsc >= CNT_W'(PACKS - 1)) &&
                       ((fhdc_pkg::flush_bits(r_hb) & fhdc_pkg::ABS_MASK) == 32'd0);
    assign w_dup     = w_probe[PACKS].match || w_cnt_row;

    // ---- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invis <= 6'd17;
        end else if (i_cfg_valid) begin
            r_invis <= i_cfg_data;
        end
    end

    // ---- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_step       <= HS_SUM;
            r_issued     <= 1'b0;
            r_crash      <= 1'b0;
            r_ins_todo   <= 1'b0;
            r_pack_count <= '0;
            r_bsc        <= '0;
            r_fill_pack  <= '0;
            r_fill_lane  <= '0;
            r_pend_num   <= '0;
            r_cidx       <= '0;
            r_inj_v      <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_v1y      <= i_v1y;
                        r_v1z      <= i_v1z;
                        r_v2x      <= i_v2x;
                        r_v2y      <= i_v2y;
                        r_v2z      <= i_v2z;
                        r_surf     <= i_surface_tag[25:20];
                        r_vzero    <= (i_valid_word & fhdc_pkg::EXP_MASK) == 32'd0;
                        r_last     <= i_batch_last;
                        r_crash    <= i_func;
                        r_ins_todo <= 1'b0;
                        r_skip     <= 1'b0;
                        r_dup      <= 1'b0;
                        r_ins      <= 1'b0;
                        r_opack    <= '0;
                        r_olane    <= '0;
                        r_hb       <= 32'd0;
                        r_step     <= HS_SUM;
                        r_issued   <= 1'b0;
                        r_cidx     <= '0;
                        r_state    <= i_func ? ST_COMMIT : ST_HASH;
                    end
                end
                ST_HASH: begin
                    if (w_fstart) begin
                        r_issued <= 1'b1;
                    end
                    if (w_fdone) begin
                        r_issued <= 1'b0;
                        case (r_step)
                            HS_SUM: begin r_s <= w_fres; r_step <= HS_MUL; end
                            HS_MUL: begin r_m <= w_fres; r_step <= HS_T;   end
                            HS_T:   begin r_t <= w_fres; r_step <= HS_P;   end
                            HS_P:   begin r_t <= w_fres; r_step <= HS_H;   end
                            default: begin
                                r_hb   <= w_hb;
                                r_skip <= w_skip || r_vzero;
                                if (w_skip || r_vzero) begin
                                    r_state <= r_last ? ST_COMMIT : ST_FIN;
                                end else begin
                                    r_inj_v    <= 1'b1;
                                    r_inj_hash <= fhdc_pkg::flush_bits(w_hb);
                                    r_state    <= ST_SCAN;
                                end
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    // probe enters the chain for one cycle only
                    r_inj_v <= 1'b0;
                    if (w_probe[PACKS].valid) begin
                        r_dup <= w_dup;
                        if (!w_dup && (r_pend_num == fhdc_pkg::PEND_W'(fhdc_pkg::PEND_DEPTH)))
                        begin
                            // queue full: flush it before taking the new slot
                            r_ins_todo <= 1'b1;
                            r_state    <= ST_COMMIT;
                        end else if (!w_dup) begin
                            r_state <= ST_INS;
                        end else begin
                            r_state <= r_last ? ST_COMMIT : ST_FIN;
                        end
                    end
                end
                ST_COMMIT: begin
                    if (r_cidx < r_pend_num) begin
                        r_cidx <= r_cidx + 1'b1;
                    end else begin
                        r_pend_num <= '0;
                        r_cidx     <= '0;
                        if (r_ins_todo) begin
                            r_state <= ST_INS;
                        end else if (r_crash) begin
                            r_pack_count <= '0;
                            r_bsc        <= '0;
                            r_fill_pack  <= '0;
                            r_fill_lane  <= '0;
                            r_state      <= ST_FIN;
                        end else begin
                            r_bsc   <= r_pack_count;
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_INS: begin
                    r_ins_todo <= 1'b0;
                    r_ins      <= 1'b1;
                    r_opack    <= r_fill_pack;
                    r_olane    <= r_fill_lane;
                    r_pend_hash[r_pend_num[fhdc_pkg::PIDX_W-1:0]] <= r_hb;
                    r_pend_pack[r_pend_num[fhdc_pkg::PIDX_W-1:0]] <= r_fill_pack;
                    r_pend_lane[r_pend_num[fhdc_pkg::PIDX_W-1:0]] <= r_fill_lane;
                    r_pend_num <= r_pend_num + 1'b1;
                    if (r_fill_lane == LANE_W'(LANES - 1)) begin
                        r_fill_lane <= '0;
                        r_fill_pack <= (r_fill_pack == PACK_W'(PACKS - 1)) ? '0
                                                                           : r_fill_pack + 1'b1;
                        if (r_pack_count != CNT_W'(PACKS)) begin
                            r_pack_count <= r_pack_count + 1'b1;
                        end
                    end else begin
                        r_fill_lane <= r_fill_lane + 1'b1;
                    end
                    r_state <= r_last ? ST_COMMIT : ST_FIN;
                end
                ST_FIN: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_done      = (r_state == ST_FIN);
    assign o_skipped   = r_skip;
    assign o_duplicate = r_dup;
    assign o_inserted  = r_ins;
    assign o_slot_pack = r_opack;
    assign o_slot_lane = r_olane;
    assign o_hash_bits = r_hb;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== rtl/fhdc_fpu.sv =====
// Pipelined single-precision add / multiply unit, round to nearest even.
module fhdc_fpu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  fhdc_pkg::t_fop     i_op,
    input  logic [31:0]        i_a,
    input  logic [31:0]        i_b,
    output logic               o_done,
    output logic [31:0]        o_res
);

    function automatic logic [5:0] lzc48(input logic [47:0] m);
        logic [5:0] z;
        z = 6'd0;
        for (int i = 0; i < 48; i++) begin
            if (m[i]) begin
                z = 6'(47 - i);
            end
        end
        lzc48 = z;
    endfunction

    // ---- stage 1: unpack, align and add, or multiply
    logic [7:0]         w_ea, w_eb, w_eae, w_ebe, w_ebig, w_esm;
    logic [22:0]        w_fa, w_fb;
    logic [23:0]        w_ma, w_mb, w_mbig, w_msm;
    logic               w_sa, w_sb, w_sbig, w_ssm, w_a_big;
    logic               w_anan, w_bnan, w_ainf, w_binf, w_azero, w_bzero;
    logic [7:0]         w_diff;
    logic [4:0]         w_ash;
    logic [53:0]        w_ext;
    logic [26:0]        w_al, w_big27;
    logic [27:0]        w_sum;
    logic [47:0]        w_prod;
    logic               n_spec, n_sign, n_zsign;
    logic [31:0]        n_spec_res;
    logic signed [10:0] n_eb;
    logic [47:0]        n_m;

    always_comb begin
        w_ea  = i_a[30:23];
        w_eb  = i_b[30:23];
        w_fa  = i_a[22:0];
        w_fb  = i_b[22:0];
        w_sa  = i_a[31];
        w_sb  = i_b[31];
        w_anan  = (w_ea == 8'hFF) && (w_fa != 23'd0);
        w_bnan  = (w_eb == 8'hFF) && (w_fb != 23'd0);
        w_ainf  = (w_ea == 8'hFF) && (w_fa == 23'd0);
        w_binf  = (w_eb == 8'hFF) && (w_fb == 23'd0);
        w_azero = (w_ea == 8'd0) && (w_fa == 23'd0);
        w_bzero = (w_eb == 8'd0) && (w_fb == 23'd0);
        w_ma  = {w_ea != 8'd0, w_fa};
        w_mb  = {w_eb != 8'd0, w_fb};
        w_eae = (w_ea == 8'd0) ? 8'd1 : w_ea;
        w_ebe = (w_eb == 8'd0) ? 8'd1 : w_eb;

        // addition: larger magnitude first
        w_a_big = i_a[30:0] >= i_b[30:0];
        w_ebig  = w_a_big ? w_eae : w_ebe;
        w_esm   = w_a_big ? w_ebe : w_eae;
        w_mbig  = w_a_big ? w_ma : w_mb;
        w_msm   = w_a_big ? w_mb : w_ma;
        w_sbig  = w_a_big ? w_sa : w_sb;
        w_ssm   = w_a_big ? w_sb : w_sa;
        w_diff  = w_ebig - w_esm;
        w_ash   = (w_diff > 8'd31) ? 5'd31 : w_diff[4:0];
        w_ext   = {w_msm, 3'b000, 27'd0} >> w_ash;
        w_al    = w_ext[53:27] | {26'd0, |w_ext[26:0]};
        w_big27 = {w_mbig, 3'b000};
        w_sum   = (w_sbig == w_ssm) ? ({1'b0, w_big27} + {1'b0, w_al})
                                    : ({1'b0, w_big27} - {1'b0, w_al});
        w_prod  = w_ma * w_mb;

        case (i_op)
            fhdc_pkg::FOP_MUL: begin
                n_spec  = w_anan || w_bnan || w_ainf || w_binf;
                n_sign  = w_sa ^ w_sb;
                n_zsign = w_sa ^ w_sb;
                if (w_anan || w_bnan || (w_ainf && w_bzero) || (w_binf && w_azero)) begin
                    n_spec_res = fhdc_pkg::QNAN_BITS;
                end else begin
                    n_spec_res = {w_sa ^ w_sb, 8'hFF, 23'd0};
                end
                n_eb = signed'({3'd0, w_eae}) + signed'({3'd0, w_ebe}) - 11'sd126;
                n_m  = w_prod;
            end
            default: begin
                n_spec  = w_anan || w_bnan || w_ainf || w_binf;
                n_sign  = w_sbig;
                n_zsign = (w_sa == w_sb) ? w_sa : 1'b0;
                if (w_anan || w_bnan || (w_ainf && w_binf && (w_sa != w_sb))) begin
                    n_spec_res = fhdc_pkg::QNAN_BITS;
                end else begin
                    n_spec_res = {w_ainf ? w_sa : w_sb, 8'hFF, 23'd0};
                end
                n_eb = signed'({3'd0, w_ebig}) + 11'sd1;
                n_m  = {w_sum, 20'd0};
            end
        endcase
    end

    logic               r1_v, r2_v, r3_v, r4_v;
    logic               r1_spec, r2_spec, r3_spec;
    logic               r1_sign, r2_sign, r3_sign;
    logic               r1_zsign, r2_zsign, r3_zsign;
    logic [31:0]        r1_spec_res, r2_spec_res, r3_spec_res, r4_res;
    logic signed [10:0] r1_eb, r2_eb, r3_eb;
    logic [47:0]        r1_m, r2_m, r3_m;
    logic [5:0]         r2_z;

    // ---- stage 4: denormalise, round and pack
    logic [10:0]  w_dsh_raw;
    logic [5:0]   w_dsh;
    logic [95:0]  w_dext;
    logic [47:0]  w_mm;
    logic         w_st2, w_rup;
    logic [7:0]   w_field;
    logic [30:0]  w_packed, w_rounded;
    logic [31:0]  n_res;

    always_comb begin
        w_dsh_raw = 11'(11'sd1 - r3_eb);
        w_dsh     = (w_dsh_raw > 11'd63) ? 6'd63 : w_dsh_raw[5:0];
        w_dext    = {r3_m, 48'd0} >> w_dsh;
        if (r3_eb < 11'sd1) begin
            w_mm    = w_dext[95:48];
            w_st2   = |w_dext[47:0];
            w_field = 8'd0;
        end else begin
            w_mm    = r3_m;
            w_st2   = 1'b0;
            w_field = r3_eb[7:0];
        end
        w_packed  = {w_field, w_mm[46:24]};
        w_rup     = w_mm[23] && ((|w_mm[22:0]) || w_st2 || w_mm[24]);
        w_rounded = w_packed + {30'd0, w_rup};
        if (r3_spec) begin
            n_res = r3_spec_res;
        end else if (r3_m == 48'd0) begin
            n_res = {r3_zsign, 31'd0};
        end else if (r3_eb >= 11'sd255) begin
            n_res = {r3_sign, 8'hFF, 23'd0};
        end else begin
            n_res = {r3_sign, w_rounded};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            r1_v <= i_start;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_spec     <= n_spec;
        r1_sign     <= n_sign;
        r1_zsign    <= n_zsign;
        r1_spec_res <= n_spec_res;
        r1_eb       <= n_eb;
        r1_m        <= n_m;
        // stage 2: leading zero count
        r2_spec     <= r1_spec;
        r2_sign     <= r1_sign;
        r2_zsign    <= r1_zsign;
        r2_spec_res <= r1_spec_res;
        r2_eb       <= r1_eb;
        r2_m        <= r1_m;
        r2_z        <= lzc48(r1_m);
        // stage 3: normalising shift
        r3_spec     <= r2_spec;
        r3_sign     <= r2_sign;
        r3_zsign    <= r2_zsign;
        r3_spec_res <= r2_spec_res;
        r3_eb       <= r2_eb - signed'({5'd0, r2_z});
        r3_m        <= r2_m << r2_z;
        r4_res      <= n_res;
    end

    assign o_done = r4_v;
    assign o_res  = r4_res;

endmodule

// ===== rtl/fhdc_cell.sv =====
// One pack of stored hashes; compares the passing probe and hands it on.
module fhdc_cell #(
    parameter int LANES  = 4,
    parameter int PACK_W = 6,
    parameter int LANE_W = 2,
    parameter int INDEX  = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fhdc_pkg::t_probe      i_probe,
    input  logic [PACK_W-1:0]     i_last_pack,
    input  logic                  i_wr,
    input  logic [PACK_W-1:0]     i_wr_pack,
    input  logic [LANE_W-1:0]     i_wr_lane,
    input  logic [31:0]           i_wr_hash,
    output fhdc_pkg::t_probe      o_probe
);

    logic [31:0]      r_hash [LANES];
    fhdc_pkg::t_probe r_probe;
    logic             w_hit;

    always_comb begin
        w_hit = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            if (fhdc_pkg::hash_eq(r_hash[l], i_probe.hash)) begin
                w_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LANES; l++) begin
                r_hash[l] <= 32'd0;
            end
            r_probe <= '0;
        end else begin
            if (i_wr && (i_wr_pack == PACK_W'(INDEX))) begin
                r_hash[i_wr_lane] <= i_wr_hash;
            end
            r_probe.valid <= i_probe.valid;
            r_probe.hash  <= i_probe.hash;
            r_probe.match <= i_probe.match ||
                             (w_hit && (PACK_W'(INDEX) <= i_last_pack));
        end
    end

    assign o_probe = r_probe;

endmodule

// ===== rtl/fhdc_chk.sv =====
// Port-level checks of the dedup cache, bound to the top level.
module fhdc_chk #(
    parameter int PACK_W = 6,
    parameter int LANE_W = 2
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_start,
    input logic              o_busy,
    input logic              o_done,
    input logic              o_skipped,
    input logic              o_duplicate,
    input logic              o_inserted,
    input logic [PACK_W-1:0] o_slot_pack,
    input logic [LANE_W-1:0] o_slot_lane
);

    // an accepted item keeps the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after accepting an item");

    // result strobe only while busy, and the block frees right after it
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy ##1 !o_busy)
        else $error("busy does not drop after a result");

    // at most one outcome per triangle
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $onehot0({o_skipped, o_duplicate, o_inserted}))
        else $error("more than one outcome flag set");

    // no slot reported unless one was given
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_inserted) |-> (o_slot_pack == '0) && (o_slot_lane == '0))
        else $error("slot reported without insertion");

endmodule

bind float_hash_dedup_ring_cache_core fhdc_chk #(
    .PACK_W ($clog2(PACKS)),
    .LANE_W ($clog2(LANES))
) u_fhdc_chk (.*);

// ===== tb/tb.sv =====
// Testbench of the triangle hash dedup cache: directed and random items, predicted and checked.
`timescale 1ns / 100ps

module tb;

    localparam int PACKS   = 48;
    localparam int LANES   = 4;
    localparam int SLOTS   = PACKS * LANES;
    localparam int SETTLE  = 120;       // cycles of quiet before a register write
    localparam int N_RAND  = 640;

    // what an entry of the pending list asks the driver to do
    typedef enum logic [1:0] {
        JOB_ITEM  = 2'd0,
        JOB_CFG   = 2'd1,
        JOB_DRAIN = 2'd2
    } t_job;

    typedef enum logic {
        FN_TRI   = 1'b0,
        FN_CRASH = 1'b1
    } t_func;

    typedef struct {
        t_job        job;
        t_func       func;
        logic [31:0] v1y, v1z, v2x, v2y, v2z;
        logic [31:0] tag, vword;
        logic        last;
        logic [5:0]  cfg;
    } t_tri;

    typedef struct {
        logic        skipped, duplicate, inserted;
        logic [5:0]  pack;
        logic [1:0]  lane;
        logic [31:0] hash;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic        i_func = 1'b0;
    logic [31:0] i_v1y = '0, i_v1z = '0, i_v2x = '0, i_v2y = '0, i_v2z = '0;
    logic [31:0] i_surface_tag = '0, i_valid_word = '0;
    logic        i_batch_last = 1'b0;
    logic        o_done, o_skipped, o_duplicate, o_inserted;
    logic [5:0]  o_slot_pack;
    logic [1:0]  o_slot_lane;
    logic [31:0] o_hash_bits;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data = '0;

    float_hash_dedup_ring_cache_core #(.PACKS(PACKS), .LANES(LANES)) dut (.*);

    always #4 i_clk = ~i_clk;

    // mirror of the cache state
    logic [5:0]  inv_id = 6'd17;
    logic [31:0] ring_hash [SLOTS];
    int unsigned packs_full, fill_pack, fill_lane, start_count, pend_n;
    logic [31:0] pend_hash [4];
    int unsigned pend_slot [4];

    t_tri        tri_q[$];
    t_verdict    verdict_q[$];
    bit          failed = 1'b0;

    // ---- single precision arithmetic via exact widening to double ----
    function automatic real single_to_real(logic [31:0] b);
        logic [63:0] d;
        if (b[30:23] == 8'hFF) begin
            d = (b[22:0] != 0) ? 64'h7FF8_0000_0000_0000 : {b[31], 11'h7FF, 52'd0};
            return $bitstoreal(d);
        end
        if (b[30:23] == 8'd0) begin
            if (b[22:0] == 0) return $bitstoreal({b[31], 63'd0});
            return (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * (2.0 ** -149);
        end
        d = {b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0};
        return $bitstoreal(d);
    endfunction

    // round a double to the nearest single, ties to even
    function automatic logic [31:0] real_to_single(real r);
        logic [63:0] d, sig, kept, rem, half;
        int          ex, sh;
        logic [31:0] mag;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? fhdc_pkg::QNAN_BITS : {d[63], 31'h7F80_0000};
        if (d[62:52] == 11'd0) return {d[63], 31'd0};
        ex  = int'(d[62:52]) - 1023;
        if (ex > 127) return {d[63], 31'h7F80_0000};
        sig = {11'd1, d[51:0]};
        sh  = (ex >= -126) ? 29 : 29 + (-126 - ex);
        if (sh > 55) return {d[63], 31'd0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0])) kept = kept + 1;
        if (ex >= -126) kept = kept + (64'(ex + 126) << 23);
        mag = (kept >= 64'h7F80_0000) ? 32'h7F80_0000 : kept[31:0];
        return {d[63], mag[30:0]};
    endfunction

    function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
        return real_to_single(single_to_real(a) + single_to_real(b));
    endfunction

    function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
        return real_to_single(single_to_real(a) * single_to_real(b));
    endfunction

    function automatic logic [31:0] to_zero_if_tiny(logic [31:0] b);
        return (b[30:23] == 8'd0) ? {b[31], 31'd0} : b;
    endfunction

    function automatic bit same_hash(logic [31:0] a, logic [31:0] b);
        if ((a & fhdc_pkg::ABS_MASK) > fhdc_pkg::EXP_MASK ||
            (b & fhdc_pkg::ABS_MASK) > fhdc_pkg::EXP_MASK) return 1'b0;
        if ((a & fhdc_pkg::ABS_MASK) == 0 && (b & fhdc_pkg::ABS_MASK) == 0) return 1'b1;
        return a == b;
    endfunction

    task automatic flush_pending();
        for (int i = 0; i < pend_n; i++) ring_hash[pend_slot[i]] = pend_hash[i];
        pend_n = 0;
    endtask

    // cache behaviour for one accepted item
    task automatic cache_lookup(t_tri c);
        t_verdict    v;
        logic [31:0] s, m, t, p, h, fh;
        int unsigned top;
        v = '{default: '0};
        if (c.func == FN_CRASH) begin
            flush_pending();
            packs_full = 0; fill_pack = 0; fill_lane = 0; start_count = 0;
            verdict_q.push_back(v);
            return;
        end
        s = fadd(c.v2x, c.v2y);
        m = fmul(c.v1y, c.v1z);
        t = fadd(m, s);
        p = fmul(s, t);
        h = fadd(p, c.v2z);
        if ((h & fhdc_pkg::ABS_MASK) > fhdc_pkg::EXP_MASK) h = fhdc_pkg::QNAN_BITS;
        v.hash    = h;
        v.skipped = (c.tag[25:20] == inv_id) || (c.vword[30:23] == 8'd0);
        if (!v.skipped) begin
            fh  = to_zero_if_tiny(h);
            top = (start_count + 1 > PACKS - 1) ? PACKS - 1 : start_count + 1;
            for (int i = 0; i < (top + 1) * LANES; i++)
                if (same_hash(to_zero_if_tiny(ring_hash[i]), fh)) v.duplicate = 1'b1;
            // saturated ring: the counter row reads as a zero hash
            if (start_count >= PACKS - 1 && (fh & fhdc_pkg::ABS_MASK) == 0) v.duplicate = 1'b1;
            v.inserted = !v.duplicate;
        end
        if (v.inserted) begin
            if (pend_n >= 4) flush_pending();
            v.pack = fill_pack[5:0];
            v.lane = fill_lane[1:0];
            pend_hash[pend_n] = h;
            pend_slot[pend_n] = fill_pack * LANES + fill_lane;
            pend_n++;
            fill_lane = (fill_lane + 1) % LANES;
            if (fill_lane == 0) begin
                fill_pack = (fill_pack + 1) % PACKS;
                if (packs_full < PACKS) packs_full++;
            end
        end
        if (c.last) begin
            flush_pending();
            start_count = packs_full;
        end
        verdict_q.push_back(v);
    endtask

    // ---- stimulus ----
    function automatic logic [31:0] pick_float();
        logic [31:0] pool [12] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
                                   32'h4000_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h7F80_0000,
                                   32'hFF80_0000, 32'h7FC0_0001, 32'h7F7F_FFFF, 32'h4040_0000};
        case ($urandom_range(0, 3))
            0:       return pool[$urandom_range(0, 11)];
            1:       return $urandom;
            default: return {$urandom_range(0, 1) == 1, 8'($urandom_range(120, 134)),
                             23'($urandom_range(0, 7)) << 20};
        endcase
    endfunction

    task automatic add_tri(t_func f, logic [31:0] a, b, c, d, e, tag, vw, logic last);
        t_tri x;
        x = '{job: JOB_ITEM, func: f, v1y: a, v1z: b, v2x: c, v2y: d, v2z: e,
              tag: tag, vword: vw, last: last, cfg: '0};
        tri_q.push_back(x);
    endtask

    task automatic add_job(t_job j, logic [5:0] val);
        t_tri x;
        x = '{job: j, func: FN_TRI, v1y: '0, v1z: '0, v2x: '0, v2y: '0, v2z: '0,
              tag: '0, vword: '0, last: 1'b0, cfg: val};
        tri_q.push_back(x);
    endtask

    localparam logic [31:0] ONE = 32'h3F80_0000;
    localparam logic [31:0] TAG = 32'h0000_0000;   // surface id 0

    initial begin
        t_tri hist [$];
        t_tri x;
        // directed: extremes, skips, special hashes, duplicates, pending overflow
        add_tri(FN_TRI, ONE, ONE, ONE, ONE, ONE, TAG, ONE, 1'b0);
        add_tri(FN_TRI, ONE, ONE, ONE, ONE, ONE, TAG, ONE, 1'b1);   // same batch, unseen
        add_tri(FN_TRI, ONE, ONE, ONE, ONE, ONE, TAG, ONE, 1'b1);   // now a duplicate
        add_tri(FN_TRI, ONE, ONE, ONE, ONE, ONE, 32'h0110_0000, ONE, 1'b0); // invisible id
        add_tri(FN_TRI, ONE, ONE, ONE, ONE, ONE, TAG, 32'h8000_0000, 1'b0); // valid is -0
        add_tri(FN_TRI, ONE, ONE, ONE, ONE, ONE, TAG, 32'h007F_FFFF, 1'b0); // valid denormal
        add_tri(FN_TRI, '0, '0, '0, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0); // zero hash
        add_tri(FN_TRI, '0, '0, '0, '0, 32'h8000_0001, TAG, ONE, 1'b0); // denormal, equals zero
        add_tri(FN_TRI, 32'h7F80_0000, '0, ONE, ONE, ONE, TAG, ONE, 1'b0); // NaN hash
        add_tri(FN_TRI, 32'h7F80_0000, '0, ONE, ONE, ONE, TAG, ONE, 1'b1); // NaN never matches
        add_tri(FN_TRI, 32'h7F7F_FFFF, 32'h7F7F_FFFF, ONE, ONE, ONE, TAG, ONE, 1'b0); // inf
        add_tri(FN_TRI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        for (int i = 0; i < 6; i++)           // more than four unique in one batch
            add_tri(FN_TRI, ONE, ONE, ONE, ONE, 32'h4100_0000 + (i << 20), TAG, ONE, i == 5);
        add_tri(FN_CRASH, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, 1'b1);
        add_tri(FN_TRI, ONE, ONE, ONE, ONE, ONE, TAG, ONE, 1'b1);   // still stored after crash
        add_job(JOB_DRAIN, '0);
        add_job(JOB_CFG, 6'd63);
        add_tri(FN_TRI, ONE, ONE, ONE, ONE, 32'h4200_0000, 32'h03F0_0000, ONE, 1'b1);
        add_tri(FN_TRI, ONE, ONE, ONE, ONE, 32'h4200_0000, 32'h0110_0000, ONE, 1'b1);

        // random: batches of mostly fresh hashes with repeats of earlier triangles
        for (int n = 0; n < N_RAND; n++) begin
            if (n == 180) add_job(JOB_CFG, 6'd0);
            if (n == 360) add_job(JOB_CFG, 6'($urandom));
            if (n == 520) add_job(JOB_DRAIN, '0);
            if (n == 540) add_job(JOB_CFG, 6'd17);
            if (hist.size() > 0 && $urandom_range(0, 4) == 0) begin
                x = hist[$urandom_range(0, hist.size() - 1)];
            end else begin
                x = '{job: JOB_ITEM, func: FN_TRI, v1y: pick_float(), v1z: pick_float(),
                      v2x: pick_float(), v2y: pick_float(), v2z: pick_float(),
                      tag: $urandom, vword: $urandom, last: 1'b0, cfg: '0};
                if ($urandom_range(0, 2) != 0) x.tag[25:20] = 6'($urandom_range(0, 3));
                if ($urandom_range(0, 9) == 0) x.vword[30:23] = 8'd0;
                else if (x.vword[30:23] == 8'd0) x.vword[23] = 1'b1;
                hist.push_back(x);
                if (hist.size() > 40) void'(hist.pop_front());
            end
            x.last = ($urandom_range(0, 3) == 0);
            x.func = ($urandom_range(0, 229) == 0) ? FN_CRASH : FN_TRI;
            tri_q.push_back(x);
        end
    end

    // ---- driver ----
    int unsigned burst_left = 5, gap_left = 0, quiet = 0;

    always @(posedge i_clk) begin
        if (o_done || o_busy || verdict_q.size() != 0) quiet <= 0;
        else quiet <= quiet + 1;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                inv_id      = i_cfg_data;
                i_cfg_valid <= 1'b0;
            end
            if (i_start && !o_busy) begin
                cache_lookup('{job: JOB_ITEM, func: t_func'(i_func), v1y: i_v1y, v1z: i_v1z,
                               v2x: i_v2x, v2y: i_v2y, v2z: i_v2z, tag: i_surface_tag,
                               vword: i_valid_word, last: i_batch_last, cfg: '0});
                i_start <= 1'b0;
            end else if (!i_start && !i_cfg_valid && tri_q.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                end else if (tri_q[0].job != JOB_ITEM) begin
                    // register writes and drain points wait for an idle block
                    if (quiet >= SETTLE) begin
                        if (tri_q[0].job == JOB_CFG) begin
                            i_cfg_data  <= tri_q[0].cfg;
                            i_cfg_valid <= 1'b1;
                        end
                        void'(tri_q.pop_front());
                    end
                end else begin
                    i_func        <= tri_q[0].func;
                    i_v1y         <= tri_q[0].v1y;
                    i_v1z         <= tri_q[0].v1z;
                    i_v2x         <= tri_q[0].v2x;
                    i_v2y         <= tri_q[0].v2y;
                    i_v2z         <= tri_q[0].v2z;
                    i_surface_tag <= tri_q[0].tag;
                    i_valid_word  <= tri_q[0].vword;
                    i_batch_last  <= tri_q[0].last;
                    i_start       <= 1'b1;
                    void'(tri_q.pop_front());
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin
        t_verdict e;
        if (i_rst_n && o_done) begin
            if (verdict_q.size() == 0) begin
                $error("result with nothing expected");
                failed <= 1'b1;
            end else begin
                e = verdict_q.pop_front();
                if (o_skipped !== e.skipped) begin
                    $error("skipped: expected %0d got %0d", e.skipped, o_skipped);
                    failed <= 1'b1;
                end
                if (o_duplicate !== e.duplicate) begin
                    $error("duplicate: expected %0d got %0d", e.duplicate, o_duplicate);
                    failed <= 1'b1;
                end
                if (o_inserted !== e.inserted) begin
                    $error("inserted: expected %0d got %0d", e.inserted, o_inserted);
                    failed <= 1'b1;
                end
                if (o_slot_pack !== e.pack) begin
                    $error("slot_pack: expected %0d got %0d", e.pack, o_slot_pack);
                    failed <= 1'b1;
                end
                if (o_slot_lane !== e.lane) begin
                    $error("slot_lane: expected %0d got %0d", e.lane, o_slot_lane);
                    failed <= 1'b1;
                end
                if (o_hash_bits !== e.hash) begin
                    $error("hash_bits: expected %08h got %08h", e.hash, o_hash_bits);
                    failed <= 1'b1;
                end
            end
        end
    end

    // reset, then wait for the stimulus to run dry and the results to come home
    initial begin
        for (int i = 0; i < SLOTS; i++) ring_hash[i] = '0;
        packs_full = 0; fill_pack = 0; fill_lane = 0; start_count = 0; pend_n = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        wait (tri_q.size() == 0 && !i_start && !i_cfg_valid);
        wait (verdict_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (!failed && verdict_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
